// File: hdl/tum_pkg.sv
// shared types and constants of the trajectory unit merger
package tum_pkg;

	localparam int TIME_BITS = 48;
	localparam int POSITION_BITS = 32;
	localparam int NET_BITS = 31;
	localparam int ROUTE_BITS = 31;
	localparam int SIDE_BITS = 2;
	localparam int TOL_BITS = 47;
	localparam int FRAC_SHIFT = 16;
	localparam int QUO_BITS = POSITION_BITS + FRAC_SHIFT;
	localparam int SPEED_BITS = 48;
	localparam int STEP_BITS = $clog2(QUO_BITS + 1);

	localparam logic [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS - 1){1'b1}}};

	typedef struct packed {
		logic [TIME_BITS-1:0]     unit_start_time;
		logic [TIME_BITS-1:0]     unit_end_time;
		logic [NET_BITS-1:0]      network_number;
		logic [ROUTE_BITS-1:0]    route_number;
		logic [SIDE_BITS-1:0]     route_side;
		logic [POSITION_BITS-1:0] start_position;
		logic [POSITION_BITS-1:0] end_position;
		logic                     final_unit;
	} in_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]     merged_start_time;
		logic [TIME_BITS-1:0]     merged_end_time;
		logic [NET_BITS-1:0]      out_network;
		logic [ROUTE_BITS-1:0]    out_route;
		logic [SIDE_BITS-1:0]     out_side;
		logic [POSITION_BITS-1:0] merged_start_position;
		logic [POSITION_BITS-1:0] merged_end_position;
		logic                     last_of_burst;
	} out_item_t;

	typedef struct packed {
		logic open_run;
		logic diff;
		logic mag;
		logic cmp;
		logic update;
	} run_cmd_t;

	typedef struct packed {
		logic                     run_open;
		logic                     differs;
		logic [ROUTE_BITS-1:0]    route;
		logic [SIDE_BITS-1:0]     side;
		logic [TIME_BITS-1:0]     begin_time;
		logic [POSITION_BITS-1:0] begin_position;
		logic [TIME_BITS-1:0]     prev_end_time;
		logic [POSITION_BITS-1:0] prev_end_position;
	} run_view_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: hdl/tum_divider.sv
// iterative radix-2 speed divider with sign handling and saturation
module tum_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tum_pkg::POSITION_BITS-1:0] start_position,
	input  logic [tum_pkg::POSITION_BITS-1:0] end_position,
	input  logic [tum_pkg::TIME_BITS-1:0]     start_time,
	input  logic [tum_pkg::TIME_BITS-1:0]     end_time,
	output logic [tum_pkg::SPEED_BITS-1:0]    speed,
	output tum_pkg::div_status_t              status
);

	typedef enum logic [2:0] {
		D_IDLE   = 3'b001,
		D_RUN    = 3'b010,
		D_FINISH = 3'b100
	} div_state_t;

	div_state_t                        state_q;
	logic [tum_pkg::STEP_BITS-1:0]     step_q;
	logic                              done_q;
	logic [tum_pkg::QUO_BITS-1:0]      dividend_q;
	logic [tum_pkg::TIME_BITS-1:0]     den_q;
	logic [tum_pkg::TIME_BITS-1:0]     rem_q;
	logic [tum_pkg::QUO_BITS-1:0]      quo_q;
	logic                              neg_q;
	logic                              zero_q;
	logic [tum_pkg::SPEED_BITS-1:0]    speed_q;

	logic [tum_pkg::POSITION_BITS-1:0] num;
	logic [tum_pkg::TIME_BITS-1:0]     den;
	logic                              neg_p;
	logic                              neg_t;
	logic [tum_pkg::TIME_BITS+1:0]     trial;
	logic                              sat;
	logic [tum_pkg::SPEED_BITS-1:0]    mag;

	always_comb begin
		neg_p = end_position < start_position;
		num = neg_p ? (start_position - end_position) : (end_position - start_position);
		neg_t = end_time < start_time;
		den = neg_t ? (start_time - end_time) : (end_time - start_time);
		trial = {1'b0, rem_q, dividend_q[tum_pkg::QUO_BITS-1]} - {2'b00, den_q};
		sat = |(quo_q >> (tum_pkg::SPEED_BITS - 1));
		mag = sat ? tum_pkg::SPEED_MAX : tum_pkg::SPEED_BITS'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					step_q <= '0;
					if (start) begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == tum_pkg::STEP_BITS'(tum_pkg::QUO_BITS - 1)) begin
						state_q <= D_FINISH;
					end
				end
				D_FINISH: begin
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			dividend_q <= {num, {tum_pkg::FRAC_SHIFT{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= neg_p ^ neg_t;
			zero_q <= (num == '0);
		end else if (state_q == D_RUN) begin
			dividend_q <= dividend_q << 1;
			if (!trial[tum_pkg::TIME_BITS+1]) begin
				rem_q <= trial[tum_pkg::TIME_BITS-1:0];
			end else begin
				rem_q <= {rem_q[tum_pkg::TIME_BITS-2:0], dividend_q[tum_pkg::QUO_BITS-1]};
			end
			quo_q <= {quo_q[tum_pkg::QUO_BITS-2:0], ~trial[tum_pkg::TIME_BITS+1]};
		end else if (state_q == D_FINISH) begin
			// no movement is speed zero even over zero duration
			speed_q <= zero_q ? '0 : (neg_q ? (~mag + 1'b1) : mag);
		end
	end

	assign speed = speed_q;
	assign status.busy = (state_q != D_IDLE);
	assign status.done = done_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == D_IDLE) else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done longer than one cycle");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == D_RUN |-> step_q <= tum_pkg::STEP_BITS'(tum_pkg::QUO_BITS - 1))
		else $error("divider step count out of range");
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == D_FINISH)) else $error("divider done without finish");
`endif

endmodule

// File: hdl/tum_run.sv
// run state registers and merge decision datapath
module tum_run (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tum_pkg::run_cmd_t              cmd,
	input  tum_pkg::in_item_t              item,
	input  logic [tum_pkg::SPEED_BITS-1:0] speed,
	input  logic [tum_pkg::TOL_BITS-1:0]   tolerance,
	output tum_pkg::run_view_t             view
);

	logic                              open_q;
	logic [tum_pkg::ROUTE_BITS-1:0]    route_q;
	logic [tum_pkg::SIDE_BITS-1:0]     side_q;
	logic [tum_pkg::SPEED_BITS-1:0]    speed_q;
	logic [tum_pkg::TIME_BITS-1:0]     begin_time_q;
	logic [tum_pkg::POSITION_BITS-1:0] begin_position_q;
	logic [tum_pkg::TIME_BITS-1:0]     prev_end_time_q;
	logic [tum_pkg::POSITION_BITS-1:0] prev_end_position_q;
	logic [tum_pkg::SPEED_BITS:0]      diff_q;
	logic [tum_pkg::SPEED_BITS-1:0]    mag_q;
	logic                              differs_q;

	logic [tum_pkg::SPEED_BITS:0]      diff_neg;

	assign diff_neg = ~diff_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			route_q <= '0;
			side_q <= '0;
			speed_q <= '0;
			begin_time_q <= '0;
			begin_position_q <= '0;
			prev_end_time_q <= '0;
			prev_end_position_q <= '0;
			diff_q <= '0;
			mag_q <= '0;
			differs_q <= 1'b0;
		end else begin
			if (cmd.open_run) begin
				if (!open_q) begin
					open_q <= 1'b1;
					route_q <= item.route_number;
					side_q <= item.route_side;
					speed_q <= speed;
					begin_time_q <= item.unit_start_time;
					begin_position_q <= item.start_position;
				end
			end else if (cmd.diff) begin
				diff_q <= {speed[tum_pkg::SPEED_BITS-1], speed}
					- {speed_q[tum_pkg::SPEED_BITS-1], speed_q};
			end else if (cmd.mag) begin
				mag_q <= diff_q[tum_pkg::SPEED_BITS] ? diff_neg[tum_pkg::SPEED_BITS-1:0]
					: diff_q[tum_pkg::SPEED_BITS-1:0];
			end else if (cmd.cmp) begin
				differs_q <= (item.route_number != route_q) || (item.route_side != side_q)
					|| (mag_q > tum_pkg::SPEED_BITS'(tolerance));
			end else if (cmd.update) begin
				if (item.final_unit) begin
					open_q <= 1'b0;
				end else if (differs_q) begin
					route_q <= item.route_number;
					side_q <= item.route_side;
					speed_q <= speed;
					begin_time_q <= item.unit_start_time;
					begin_position_q <= item.start_position;
				end
				prev_end_time_q <= item.unit_end_time;
				prev_end_position_q <= item.end_position;
			end
		end
	end

	assign view.run_open = open_q;
	assign view.differs = differs_q;
	assign view.route = route_q;
	assign view.side = side_q;
	assign view.begin_time = begin_time_q;
	assign view.begin_position = begin_position_q;
	assign view.prev_end_time = prev_end_time_q;
	assign view.prev_end_position = prev_end_position_q;

endmodule

// File: hdl/trajectory_unit_merger_core.sv
// top level: input capture, sequencer, tolerance register and output register
// each item passes through start, divide, open, diff, mag and cmp, then emits zero, one or two results
// a new item is taken only once the last one is done; output stalls can hold the emit states
// the input stalls from acceptance until the item's last result, if any, is loaded into the output register
// reset clears the sequencer, the run state, the output valid and the tolerance register
module trajectory_unit_merger_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tum_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tum_pkg::out_item_t           out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tum_pkg::TOL_BITS-1:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_START  = 9'b000000010,
		ST_DIVIDE = 9'b000000100,
		ST_OPEN   = 9'b000001000,
		ST_DIFF   = 9'b000010000,
		ST_MAG    = 9'b000100000,
		ST_CMP    = 9'b001000000,
		ST_EMIT1  = 9'b010000000,
		ST_EMIT2  = 9'b100000000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	tum_pkg::in_item_t              item_q;
	logic [tum_pkg::TOL_BITS-1:0]   tol_q;
	logic                           out_valid_q;
	tum_pkg::out_item_t             out_item_q;

	logic [tum_pkg::SPEED_BITS-1:0] speed;
	tum_pkg::div_status_t           div_status;
	tum_pkg::run_cmd_t              cmd;
	tum_pkg::run_view_t             view;
	tum_pkg::out_item_t             run_result;
	tum_pkg::out_item_t             fit_result;
	tum_pkg::out_item_t             unit_result;
	logic                           out_free;
	logic                           has_first;
	logic                           has_second;
	logic                           load_out;
	tum_pkg::out_item_t             load_item;

	tum_divider u_divider (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (state_q == ST_START),
		.start_position (item_q.start_position),
		.end_position   (item_q.end_position),
		.start_time     (item_q.unit_start_time),
		.end_time       (item_q.unit_end_time),
		.speed          (speed),
		.status         (div_status)
	);

	tum_run u_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item_q),
		.speed     (speed),
		.tolerance (tol_q),
		.view      (view)
	);

	always_comb begin
		run_result.merged_start_time = view.begin_time;
		run_result.merged_end_time = view.prev_end_time;
		run_result.out_network = item_q.network_number;
		run_result.out_route = view.route;
		run_result.out_side = view.side;
		run_result.merged_start_position = view.begin_position;
		run_result.merged_end_position = view.prev_end_position;
		run_result.last_of_burst = !item_q.final_unit;

		fit_result.merged_start_time = view.begin_time;
		fit_result.merged_end_time = item_q.unit_end_time;
		fit_result.out_network = item_q.network_number;
		fit_result.out_route = view.route;
		fit_result.out_side = view.side;
		fit_result.merged_start_position = view.begin_position;
		fit_result.merged_end_position = item_q.end_position;
		fit_result.last_of_burst = 1'b1;

		unit_result.merged_start_time = item_q.unit_start_time;
		unit_result.merged_end_time = item_q.unit_end_time;
		unit_result.out_network = item_q.network_number;
		unit_result.out_route = item_q.route_number;
		unit_result.out_side = item_q.route_side;
		unit_result.merged_start_position = item_q.start_position;
		unit_result.merged_end_position = item_q.end_position;
		unit_result.last_of_burst = 1'b1;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign has_first = item_q.final_unit || view.differs;
	assign has_second = item_q.final_unit && view.differs;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		load_out = 1'b0;
		load_item = view.differs ? run_result : fit_result;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_status.done) begin
					state_d = ST_OPEN;
				end
			end
			ST_OPEN: begin
				cmd.open_run = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_EMIT1;
			end
			ST_EMIT1: begin
				if (!has_first) begin
					cmd.update = 1'b1;
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out = 1'b1;
					if (has_second) begin
						state_d = ST_EMIT2;
					end else begin
						cmd.update = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT2: begin
				load_item = unit_result;
				if (out_free) begin
					load_out = 1'b1;
					cmd.update = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tol_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (load_out) begin
			out_item_q <= load_item;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTH
	a_second_needs_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT2 |-> item_q.final_unit && view.differs)
		else $error("second result without a differing final item");
	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.done |-> state_q == ST_DIVIDE) else $error("divider done out of sequence");
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !div_status.busy) else $error("ready while divider busy");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_START) else $error("accepted item not started");
`endif

endmodule
